[src/cps_pkg.sv]
// Column projection segmenter: shared constants, payload types and the
// per-column decision function. No dependencies.
package cps_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 4096;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int PIX_W      = 8;
  localparam int SPAN_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_THRESHOLD = 2'd2;

  localparam logic [PIX_W-1:0]  DARK_LEVEL_RST     = 8'd100;
  localparam logic [CNT_W-1:0]  SEG_THRESHOLD_RST  = 11'd10;
  localparam logic [SPAN_W-1:0] SPAN_THRESHOLD_RST = 10'd50;

  localparam int REC_DEPTH = 4;
  localparam int REC_PTR_W = $clog2(REC_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_column;
    logic             end_of_image;
  } cps_in_t;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [CNT_W-1:0] column_value;
    logic             blank_column;
    logic             last_of_run;
  } cps_out_t;

  // Finished column, handed from the pixel front end to the decision logic
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             safe;
    logic             eoi;
  } rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] value;
    logic             blank;
  } verdict_t;

  function automatic verdict_t judge(input logic [COL_W-1:0] idx,
                                     input logic [CNT_W-1:0] cnt,
                                     input logic             safe,
                                     input logic [CNT_W-1:0] nxt,
                                     input logic [CNT_W-1:0] hist0,
                                     input logic [CNT_W-1:0] hist1,
                                     input logic [CNT_W-1:0] t);
    verdict_t         r;
    logic [CNT_W-1:0] v;
    v       = cnt;
    r.blank = 1'b0;
    // gap fill between strong neighbors
    if (idx != '0 && hist0 >= t && nxt >= t && v < t) v = t;
    if (idx > COL_W'(2) && hist1 > t) v = t;
    if (v < t) begin
      if (safe) begin
        v = t;
      end else begin
        v       = '0;
        r.blank = 1'b1;
      end
    end
    r.value = v;
    return r;
  endfunction

endpackage

[src/column_projection_segmenter_core.sv]
// Column projection segmenter top level: config registers, front end,
// record queue, decision logic, result queue. Depends on cps_pkg and submodules.
//
//  channel   direction  request when            payload
//  ------------------------------------------------------------------
//  input     in         push & !full            in_item  (cps_in_t)
//  result    out        pop & !empty            result   (cps_out_t)
//  config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// One pixel per cycle unless full; per-pixel work: compare, counter update.
// A column end yields at most one verdict; an image end with a column
// pending yields two, pending column first, maybe with a stall between.
// full follows the 4-entry record queue; the decision logic stalls when the
// 4-entry result queue is full. cfg_ready is always high.
// rst clears all control state; config returns to reset values.
module column_projection_segmenter_core
  import cps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  cps_in_t               in_item,
  output logic                  empty,
  input  logic                  pop,
  output cps_out_t              result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PIX_W-1:0]  dark_level;
  logic [CNT_W-1:0]  seg_threshold;
  logic [SPAN_W-1:0] span_threshold;

  logic     accept;
  logic     rec_push, rec_pop, rec_valid;
  rec_t     rec_wr, rec_rd;
  logic     out_push, out_full;
  cps_out_t out_item;

  assign cfg_ready = 1'b1;
  assign accept    = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_level     <= DARK_LEVEL_RST;
      seg_threshold  <= SEG_THRESHOLD_RST;
      span_threshold <= SPAN_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DARK_LEVEL:     dark_level     <= cfg_data[PIX_W-1:0];
        REG_SEG_THRESHOLD:  seg_threshold  <= cfg_data[CNT_W-1:0];
        REG_SPAN_THRESHOLD: span_threshold <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  cps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .dark_level     (dark_level),
    .span_threshold (span_threshold),
    .pix_valid      (accept),
    .pix            (in_item),
    .rec_push       (rec_push),
    .rec            (rec_wr)
  );

  cps_rec_queue u_rec_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .wr_rec   (rec_wr),
    .full     (full),
    .pop      (rec_pop),
    .rd_valid (rec_valid),
    .rd_rec   (rec_rd)
  );

  cps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .seg_threshold (seg_threshold),
    .rec_valid     (rec_valid),
    .rec           (rec_rd),
    .rec_pop       (rec_pop),
    .out_full      (out_full),
    .out_push      (out_push),
    .out_item      (out_item)
  );

  cps_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_item (out_item),
    .full    (out_full),
    .pop     (pop),
    .empty   (empty),
    .rd_item (result)
  );

endmodule

[src/cps_front.sv]
// Pixel front end: per-column ink count and ink row span, emits one column
// record per finished column. Depends on cps_pkg.
module cps_front
  import cps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [PIX_W-1:0]  dark_level,
  input  logic [SPAN_W-1:0] span_threshold,
  input  logic              pix_valid,
  input  cps_in_t           pix,
  output logic              rec_push,
  output rec_t              rec
);

  logic [ROW_W-1:0] row_counter, row_counter_next;
  logic [CNT_W-1:0] running_count, running_count_next;
  logic [ROW_W-1:0] first_dark_row, first_dark_row_next;
  logic [ROW_W-1:0] last_dark_row, last_dark_row_next;

  logic             dark;
  logic             col_end;
  logic [CNT_W-1:0] cnt_upd;
  logic [ROW_W-1:0] first_upd, last_upd;

  always_comb begin
    dark      = pix.pixel < dark_level;
    col_end   = pix.end_of_column | pix.end_of_image;
    cnt_upd   = running_count;
    first_upd = first_dark_row;
    last_upd  = last_dark_row;
    if (dark) begin
      if (running_count == '0) first_upd = row_counter;
      last_upd = row_counter;
      if (running_count < CNT_W'(MAX_ROWS)) cnt_upd = running_count + CNT_W'(1);
    end

    rec_push  = pix_valid & col_end;
    rec.count = cnt_upd;
    rec.safe  = (cnt_upd != '0) &&
                (SPAN_W'(last_upd - first_upd) > span_threshold);
    rec.eoi   = pix.end_of_image;

    row_counter_next    = row_counter;
    running_count_next  = running_count;
    first_dark_row_next = first_dark_row;
    last_dark_row_next  = last_dark_row;
    if (pix_valid) begin
      if (col_end) begin
        row_counter_next    = '0;
        running_count_next  = '0;
        first_dark_row_next = '0;
        last_dark_row_next  = '0;
      end else begin
        if (row_counter < ROW_W'(MAX_ROWS - 1)) row_counter_next = row_counter + ROW_W'(1);
        running_count_next  = cnt_upd;
        first_dark_row_next = first_upd;
        last_dark_row_next  = last_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      running_count  <= '0;
      first_dark_row <= '0;
      last_dark_row  <= '0;
    end else begin
      row_counter    <= row_counter_next;
      running_count  <= running_count_next;
      first_dark_row <= first_dark_row_next;
      last_dark_row  <= last_dark_row_next;
    end
  end

endmodule

[src/cps_rec_queue.sv]
// Short queue of finished column records between front end and decision logic.
// Depends on cps_pkg.
module cps_rec_queue
  import cps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wr_rec,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output rec_t rd_rec
);

  rec_t               mem [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [REC_PTR_W:0]   count;

  logic do_push, do_pop;

  assign full     = count == (REC_PTR_W + 1)'(REC_DEPTH);
  assign rd_valid = count != '0;
  assign rd_rec   = mem[rd_ptr];
  assign do_push  = push & ~full;
  assign do_pop   = pop & rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + REC_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + REC_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (REC_PTR_W + 1)'(1);
        2'b01:   count <= count - (REC_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/cps_back.sv]
// Decision logic: one column late verdicts with look-back history, two
// verdicts at end of image with a column pending. Depends on cps_pkg.
module cps_back
  import cps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] seg_threshold,
  input  logic             rec_valid,
  input  rec_t             rec,
  output logic             rec_pop,
  input  logic             out_full,
  output logic             out_push,
  output cps_out_t         out_item
);

  logic [COL_W-1:0] column_counter, column_counter_next;
  logic [CNT_W-1:0] pending_count, pending_count_next;
  logic             pending_safe, pending_safe_next;
  logic             pending_valid, pending_valid_next;
  logic [CNT_W-1:0] hist0, hist0_next;
  logic [CNT_W-1:0] hist1, hist1_next;

  logic             go;
  logic [COL_W-1:0] pidx;
  verdict_t         vp, ve;

  always_comb begin
    go   = rec_valid & ~out_full;
    pidx = column_counter - COL_W'(1);
    vp   = judge(pidx, pending_count, pending_safe, rec.count, hist0, hist1, seg_threshold);
    ve   = judge(column_counter, rec.count, rec.safe, '0, hist0, hist1, seg_threshold);

    rec_pop             = 1'b0;
    out_push            = 1'b0;
    out_item            = '{column_index: pidx, column_value: vp.value,
                            blank_column: vp.blank, last_of_run: ~rec.eoi};
    column_counter_next = column_counter;
    pending_count_next  = pending_count;
    pending_safe_next   = pending_safe;
    pending_valid_next  = pending_valid;
    hist0_next          = hist0;
    hist1_next          = hist1;

    if (go) begin
      if (pending_valid) begin
        out_push   = 1'b1;
        hist1_next = hist0;
        hist0_next = vp.value;
        if (rec.eoi) begin
          // record stays; final column is judged when go is next high
          pending_valid_next = 1'b0;
        end else begin
          rec_pop             = 1'b1;
          pending_count_next  = rec.count;
          pending_safe_next   = rec.safe;
          column_counter_next = column_counter + COL_W'(1);
        end
      end else if (rec.eoi) begin
        out_push            = 1'b1;
        rec_pop             = 1'b1;
        out_item            = '{column_index: column_counter, column_value: ve.value,
                                blank_column: ve.blank, last_of_run: 1'b1};
        column_counter_next = '0;
        pending_count_next  = '0;
        pending_safe_next   = 1'b0;
        hist0_next          = '0;
        hist1_next          = '0;
      end else begin
        rec_pop             = 1'b1;
        pending_count_next  = rec.count;
        pending_safe_next   = rec.safe;
        pending_valid_next  = 1'b1;
        column_counter_next = column_counter + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      pending_count  <= '0;
      pending_safe   <= 1'b0;
      pending_valid  <= 1'b0;
      hist0          <= '0;
      hist1          <= '0;
    end else begin
      column_counter <= column_counter_next;
      pending_count  <= pending_count_next;
      pending_safe   <= pending_safe_next;
      pending_valid  <= pending_valid_next;
      hist0          <= hist0_next;
      hist1          <= hist1_next;
    end
  end

endmodule

[src/cps_out_queue.sv]
// Result queue feeding the output ports; head entry is shown while not empty.
// Depends on cps_pkg.
module cps_out_queue
  import cps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cps_out_t wr_item,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output cps_out_t rd_item
);

  cps_out_t             mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_PTR_W:0]   count;

  logic do_push, do_pop;

  assign full    = count == (OUT_PTR_W + 1)'(OUT_DEPTH);
  assign empty   = count == '0;
  assign rd_item = mem[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (OUT_PTR_W + 1)'(1);
        2'b01:   count <= count - (OUT_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/cps_checker.sv]
// Port-level checks for the column projection segmenter, bound to the top
// level. Depends on cps_pkg and column_projection_segmenter_core.
module cps_checker
  import cps_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input cps_out_t result
);

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  a_not_full_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.blank_column) |-> result.column_value == '0)
    else $error("blanked column with nonzero value");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind column_projection_segmenter_core cps_checker u_cps_checker (.*);

[bench/column_projection_segmenter_core_tb.sv]
// Testbench for column_projection_segmenter_core: directed table, then random
// images under changing thresholds, checked against an in-bench column predictor.
// Depends on cps_pkg and the core RTL.
module column_projection_segmenter_core_tb;
  import cps_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1330;
  localparam int CALM_ITEMS    = 250;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cps_in_t               px;
    logic                  typed;
    cps_out_t              verdict;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  cps_in_t               in_item   = '0;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full;
  logic                  empty;
  logic                  cfg_ready;
  cps_out_t              result;

  column_projection_segmenter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0]  m_dark;
  logic [CNT_W-1:0]  m_seg;
  logic [SPAN_W-1:0] m_span;
  logic [ROW_W-1:0]  m_row;
  logic [COL_W-1:0]  m_col;
  logic [CNT_W-1:0]  m_ink;
  logic [ROW_W-1:0]  m_first;
  logic [ROW_W-1:0]  m_last;
  logic [CNT_W-1:0]  m_held_cnt;
  logic              m_held_safe;
  logic              m_held_valid;
  logic [CNT_W-1:0]  m_hist0;
  logic [CNT_W-1:0]  m_hist1;

  cps_out_t  fresh[$];
  cps_out_t  pending_verdicts[$];
  stim_row_t directed[$];

  int errors = 0;
  int made   = 0;
  int quiet  = 0;
  int rx_hold = 0;
  bit calm    = 1'b0;
  bit gaps_on = 1'b0;
  bit rx_gaps = 1'b0;

  function automatic void model_reset();
    m_dark       = DARK_LEVEL_RST;
    m_seg        = SEG_THRESHOLD_RST;
    m_span       = SPAN_THRESHOLD_RST;
    m_row        = '0;
    m_col        = '0;
    m_ink        = '0;
    m_first      = '0;
    m_last       = '0;
    m_held_cnt   = '0;
    m_held_safe  = 1'b0;
    m_held_valid = 1'b0;
    m_hist0      = '0;
    m_hist1      = '0;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DARK_LEVEL:     m_dark = val[PIX_W-1:0];
      REG_SEG_THRESHOLD:  m_seg  = val[CNT_W-1:0];
      REG_SPAN_THRESHOLD: m_span = val[SPAN_W-1:0];
      default: ;
    endcase
  endfunction

  // gap fill, look-back two columns, then keep-if-safe or blank
  function automatic cps_out_t rate_column(logic [COL_W-1:0] idx, logic [CNT_W-1:0] cnt,
                                           logic safe, logic [CNT_W-1:0] nxt);
    cps_out_t         v;
    logic [CNT_W-1:0] val;
    v   = '0;
    val = cnt;
    if (idx != '0 && m_hist0 >= m_seg && nxt >= m_seg && val < m_seg) val = m_seg;
    if (idx > 2 && m_hist1 > m_seg) val = m_seg;
    if (val < m_seg) begin
      if (safe) begin
        val = m_seg;
      end else begin
        val            = '0;
        v.blank_column = 1'b1;
      end
    end
    m_hist1        = m_hist0;
    m_hist0        = val;
    v.column_index = idx;
    v.column_value = val;
    return v;
  endfunction

  function automatic void track_pixel(cps_in_t it);
    logic safe;
    fresh.delete();
    if (it.pixel < m_dark) begin
      if (m_ink == '0) m_first = m_row;
      m_last = m_row;
      if (m_ink < MAX_ROWS) m_ink = m_ink + 1'b1;
    end
    if (!it.end_of_column && !it.end_of_image) begin
      if (m_row < MAX_ROWS - 1) m_row = m_row + 1'b1;
      return;
    end
    safe = (m_ink != '0) && ((m_last - m_first) > m_span);
    if (m_held_valid) fresh = {fresh, rate_column(m_col - 1'b1, m_held_cnt, m_held_safe, m_ink)};
    if (it.end_of_image) begin
      fresh = {fresh, rate_column(m_col, m_ink, safe, '0)};
      m_held_valid = 1'b0;
      m_held_cnt   = '0;
      m_held_safe  = 1'b0;
      m_col        = '0;
      m_hist0      = '0;
      m_hist1      = '0;
    end else begin
      m_held_cnt   = m_ink;
      m_held_safe  = safe;
      m_held_valid = 1'b1;
      m_col        = m_col + 1'b1;
    end
    m_row   = '0;
    m_ink   = '0;
    m_first = '0;
    m_last  = '0;
    if (fresh.size() != 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic stim_row_t pix_row(logic [PIX_W-1:0] p, logic eoc, logic eoi);
    stim_row_t r;
    r                  = '0;
    r.kind             = ROW_PIXEL;
    r.px.pixel         = p;
    r.px.end_of_column = eoc;
    r.px.end_of_image  = eoi;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [PIX_W-1:0] p, logic eoc, logic eoi,
                                          logic [COL_W-1:0] idx, logic [CNT_W-1:0] val,
                                          logic blank);
    stim_row_t r;
    r                      = pix_row(p, eoc, eoi);
    r.typed                = 1'b1;
    r.verdict.column_index = idx;
    r.verdict.column_value = val;
    r.verdict.blank_column = blank;
    r.verdict.last_of_run  = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int ink_pct);
    if ($urandom_range(0, 19) == 0) return PIX_W'($urandom_range(0, 255));
    if ($urandom_range(1, 100) <= ink_pct && m_dark != '0)
      return PIX_W'($urandom_range(0, int'(m_dark) - 1));
    return PIX_W'($urandom_range(int'(m_dark), 255));
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_verdict(cps_out_t got);
    cps_out_t want;
    if (pending_verdicts.size() == 0) begin
      errors++;
      $display("%0t: unexpected verdict, expected none, actual col %0d value %0d blank %0b",
               $time, got.column_index, got.column_value, got.blank_column);
      return;
    end
    want = pending_verdicts.pop_front();
    compare_field("column_index", 32'(want.column_index), 32'(got.column_index));
    compare_field("column_value", 32'(want.column_value), 32'(got.column_value));
    compare_field("blank_column", 32'(want.blank_column), 32'(got.blank_column));
    compare_field("last_of_run",  32'(want.last_of_run),  32'(got.last_of_run));
  endfunction

  // result side: pop with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      rx_hold = 0;
    end else begin
      if (pop && !empty) check_verdict(result);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (!calm && rx_gaps && $urandom_range(0, 9) == 0) begin
        rx_hold = $urandom_range(0, 14);
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic feed(cps_in_t it, logic typed, cps_out_t typed_v);
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    track_pixel(it);
    if (typed) pending_verdicts = {pending_verdicts, typed_v};
    else foreach (fresh[i]) pending_verdicts = {pending_verdicts, fresh[i]};
  endtask

  task automatic hold_off(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && gaps_on && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 15));
  endtask

  task automatic send(cps_in_t it);
    calm = (made >= RANDOM_ITEMS - CALM_ITEMS);
    maybe_gap();
    feed(it, 1'b0, '0);
    made++;
  endtask

  // sender waits until every expected verdict is out, then lets the pipe settle
  task automatic drain();
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_write(idx, val);
    @(posedge clk);
  endtask

  task automatic new_settings();
    drain();
    write_reg(REG_DARK_LEVEL,
              CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(60, 200)));
    write_reg(REG_SEG_THRESHOLD,
              CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 6)));
    write_reg(REG_SPAN_THRESHOLD,
              CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 6)));
  endtask

  task automatic random_image();
    int      ncols;
    int      nrows;
    int      ink_pct;
    logic    close_img;
    cps_in_t it;
    ncols     = $urandom_range(1, 10);
    close_img = ($urandom_range(0, 5) != 0);
    for (int c = 0; c < ncols; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.pixel         = PIX_W'($urandom_range(0, 255));
        it.end_of_column = ($urandom_range(0, 3) == 0);
        it.end_of_image  = ($urandom_range(0, 7) == 0);
        send(it);
      end
      nrows = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      case ($urandom_range(0, 4))
        0:       ink_pct = 0;
        1:       ink_pct = 30;
        2:       ink_pct = 60;
        3:       ink_pct = 90;
        default: ink_pct = 100;
      endcase
      for (int r = 0; r < nrows; r++) begin
        it.pixel         = pick_pixel(ink_pct);
        it.end_of_column = (r == nrows - 1);
        it.end_of_image  = 1'b0;
        if (r == nrows - 1 && c == ncols - 1 && close_img) begin
          it.end_of_image  = 1'b1;
          it.end_of_column = 1'($urandom_range(0, 1));
        end
        send(it);
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // one column taller than MAX_ROWS: row and ink counters saturate
  task automatic long_column();
    cps_in_t it;
    write_reg(REG_DARK_LEVEL, 11'd200);
    for (int r = 0; r < MAX_ROWS + 6; r++) begin
      it.pixel         = (r < 3) ? 8'd250 : 8'd0;
      it.end_of_column = (r == MAX_ROWS + 5);
      it.end_of_image  = 1'b0;
      send(it);
    end
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    model_reset();
    gaps_on = 1'b1;
    rx_gaps = 1'b1;

    directed = '{
      known_row(8'd0,   1'b0, 1'b1, 12'd0, 11'd0, 1'b1),
      known_row(8'd255, 1'b1, 1'b1, 12'd0, 11'd0, 1'b1),
      pix_row(8'd99,  1'b1, 1'b0),
      pix_row(8'd100, 1'b0, 1'b0),
      pix_row(8'd100, 1'b1, 1'b1),
      reg_row(REG_DARK_LEVEL,     11'd255),
      reg_row(REG_SEG_THRESHOLD,  11'd2),
      reg_row(REG_SPAN_THRESHOLD, 11'd1),
      pix_row(8'd0,   1'b0, 1'b0),
      pix_row(8'd254, 1'b1, 1'b0),
      pix_row(8'd255, 1'b1, 1'b0),
      pix_row(8'd0,   1'b0, 1'b0),
      pix_row(8'd255, 1'b0, 1'b0),
      pix_row(8'd0,   1'b1, 1'b0),
      pix_row(8'd0,   1'b0, 1'b0),
      pix_row(8'd0,   1'b0, 1'b0),
      pix_row(8'd0,   1'b1, 1'b0),
      pix_row(8'd255, 1'b1, 1'b0),
      pix_row(8'd254, 1'b1, 1'b0),
      pix_row(8'd255, 1'b1, 1'b1),
      reg_row(REG_SEG_THRESHOLD,  11'd0),
      reg_row(REG_DARK_LEVEL,     11'd0),
      known_row(8'd0,   1'b0, 1'b1, 12'd0, 11'd0, 1'b0),
      reg_row(REG_SEG_THRESHOLD,  11'd2047),
      reg_row(REG_SPAN_THRESHOLD, 11'd0),
      reg_row(REG_DARK_LEVEL,     11'd255),
      pix_row(8'd0, 1'b0, 1'b0),
      known_row(8'd0,   1'b1, 1'b1, 12'd0, 11'd2047, 1'b0),
      reg_row(REG_SEG_THRESHOLD,  11'd1024),
      reg_row(REG_SPAN_THRESHOLD, 11'd1023),
      known_row(8'd254, 1'b1, 1'b1, 12'd0, 11'd0, 1'b1)
    };

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        drain();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        maybe_gap();
        feed(directed[i].px, directed[i].typed, directed[i].verdict);
      end
    end

    while (made < RANDOM_ITEMS) begin
      phase++;
      new_settings();
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 1) long_column();
      repeat ($urandom_range(4, 10)) if (made < RANDOM_ITEMS) random_image();
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
